// File: sv/rcfd_pkg.sv
// rcfd_pkg: shared types, constants and channel helpers for the rc frame decoder
// used by rcfd_cfg_regs, rcfd_collect, rcfd_decode and rc_frame_decoder_core
package rcfd_pkg;

  localparam int FRAME_LEN = 18;
  localparam int POS_W     = $clog2(FRAME_LEN);
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_LEN - 1);

  localparam int CFG_DATA_W = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int OUT_DATA_W = 144;

  localparam logic [10:0] CENTER_RST = 11'd1024;
  localparam logic [10:0] VALID_RST  = 11'd660;
  localparam logic [6:0]  DEAD_RST   = 7'd6;
  localparam logic [9:0]  CLAMP_RST  = 10'd650;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTER = 2'd0,
    CFG_VALID  = 2'd1,
    CFG_DEAD   = 2'd2,
    CFG_CLAMP  = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [10:0] center;
    logic [10:0] valid_lim;
    logic [6:0]  dead;
    logic [9:0]  clamp;
  } cfg_t;

  // byte k of the frame sits at index k
  typedef logic [FRAME_LEN-1:0][7:0] frame_t;

  typedef struct packed {
    logic   vld;
    frame_t bytes;
  } frm_t;

  // magnitude of a 12-bit signed channel, never overflows for -2047..2047
  function automatic logic [11:0] mag12(input logic signed [11:0] v);
    logic [11:0] r;
    r = v[11] ? 12'(-v) : 12'(v);
    return r;
  endfunction

endpackage

// File: sv/rc_frame_decoder_core.sv
// rc_frame_decoder_core: one byte per cycle in; a decoded result leaves after the last byte
// of an 18-byte frame passes the shift line and then the held result registers.
// throughput: one byte per cycle; input stalls only while a finished result waits
// and another complete frame is pending behind it.
// reset: asynchronous active low; config returns to defaults, held outputs clear to zero,
// the byte position returns to idle.
module rc_frame_decoder_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [7:0]                          s_axis_tdata,  // frame_byte [7:0]
  input  logic                                s_axis_tuser,  // frame_start [0]
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // stick_right_x [10:0], stick_right_y [21:11], stick_left_x [32:22],
  // stick_left_y [43:33], wheel_channel [54:44], mouse_dx [70:55],
  // mouse_dy [86:71], mouse_dz [102:87], button_left [110:103],
  // button_right [118:111], key_bits [134:119], switch_pair [138:135], zeros above
  output logic [rcfd_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  input  logic                                cfg_we_i,
  input  logic [rcfd_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [rcfd_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import rcfd_pkg::*;

  cfg_t cfg;
  frm_t frm;
  logic take, free, acc;

  assign s_axis_tready = !frm.vld || free;
  assign acc           = s_axis_tvalid && s_axis_tready;

  rcfd_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  rcfd_collect u_collect (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .acc_i   (acc),
    .byte_i  (s_axis_tdata),
    .start_i (s_axis_tuser),
    .take_i  (take),
    .frm_o   (frm)
  );

  rcfd_decode u_decode (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .frm_i      (frm),
    .take_o     (take),
    .free_o     (free),
    .out_vld_o  (m_axis_tvalid),
    .out_rdy_i  (m_axis_tready),
    .out_data_o (m_axis_tdata)
  );

endmodule

// File: sv/rcfd_cfg_regs.sv
// rcfd_cfg_regs: configuration registers of the rc frame decoder
// depends on rcfd_pkg
module rcfd_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [rcfd_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [rcfd_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output rcfd_pkg::cfg_t                 cfg_o
);
  import rcfd_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_CENTER: cfg_d.center    = cfg_data_i[10:0];
        CFG_VALID:  cfg_d.valid_lim = cfg_data_i[10:0];
        CFG_DEAD:   cfg_d.dead      = cfg_data_i[6:0];
        CFG_CLAMP:  cfg_d.clamp     = cfg_data_i[9:0];
        default:    cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.center    <= CENTER_RST;
      cfg_q.valid_lim <= VALID_RST;
      cfg_q.dead      <= DEAD_RST;
      cfg_q.clamp     <= CLAMP_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: sv/rcfd_collect.sv
// rcfd_collect: byte position counter and frame shift line
// depends on rcfd_pkg; hands a complete frame to rcfd_decode
module rcfd_collect (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           acc_i,
  input  logic [7:0]     byte_i,
  input  logic           start_i,
  input  logic           take_i,
  output rcfd_pkg::frm_t frm_o
);
  import rcfd_pkg::*;

  logic [POS_W-1:0]     pos_q, pos_d;
  logic                 vld_q, vld_d;
  logic [FRAME_LEN-1:0][7:0] line_q;

  always_comb begin
    pos_d = pos_q;
    vld_d = vld_q;
    if (take_i) vld_d = 1'b0;
    if (acc_i) begin
      if (start_i) begin
        pos_d = POS_W'(1);
      end else if (pos_q == '0) begin
        pos_d = pos_q; // idle, byte ignored
      end else if (pos_q == LAST_POS) begin
        pos_d = '0;
        vld_d = 1'b1;
      end else begin
        pos_d = pos_q + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      vld_q <= 1'b0;
    end else begin
      pos_q <= pos_d;
      vld_q <= vld_d;
    end
  end

  // newest byte enters at tap 0
  always_ff @(posedge clk_i) begin
    if (acc_i) line_q <= {line_q[FRAME_LEN-2:0], byte_i};
  end

  always_comb begin
    frm_o.vld = vld_q;
    for (int k = 0; k < FRAME_LEN; k++) begin
      frm_o.bytes[k] = line_q[FRAME_LEN-1-k];
    end
  end

endmodule

// File: sv/rcfd_decode.sv
// rcfd_decode: frame unpacking, channel checks and held result registers
// depends on rcfd_pkg; fed by rcfd_collect
module rcfd_decode (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  rcfd_pkg::cfg_t                    cfg_i,
  input  rcfd_pkg::frm_t                    frm_i,
  output logic                              take_o,
  output logic                              free_o,
  output logic                              out_vld_o,
  input  logic                              out_rdy_i,
  output logic [rcfd_pkg::OUT_DATA_W-1:0]   out_data_o
);
  import rcfd_pkg::*;

  logic signed [10:0] chan_q [5];
  logic signed [10:0] chan_d [5];
  logic [15:0] mouse_q [3];
  logic [15:0] mouse_d [3];
  logic [7:0]  btn_l_q, btn_l_d, btn_r_q, btn_r_d;
  logic [15:0] keys_q, keys_d;
  logic [3:0]  sw_q, sw_d, last_sw_q, last_sw_d;
  logic        vld_q;

  frame_t             b;
  logic [1:0]         s1, s2;
  logic               reject, bad;
  logic [10:0]        raw [5];
  logic signed [11:0] ch [5];
  logic signed [11:0] chz [5];
  logic signed [11:0] clamp_s;

  assign free_o = !vld_q || out_rdy_i;
  assign take_o = frm_i.vld && free_o;

  always_comb begin
    b      = frm_i.bytes;
    s1     = b[5][7:6];
    s2     = b[5][5:4];
    reject = (s1 == 2'd0) || (s2 == 2'd0);

    raw[0] = {b[1][2:0], b[0]};
    raw[1] = {b[2][5:0], b[1][7:3]};
    raw[2] = {b[4][0], b[3], b[2][7:6]};
    raw[3] = {b[5][3:0], b[4][7:1]};
    raw[4] = {b[17][2:0], b[16]};

    bad = 1'b0;
    for (int i = 0; i < 5; i++) begin
      ch[i] = $signed({1'b0, raw[i]}) - $signed({1'b0, cfg_i.center});
    end
    for (int i = 0; i < 4; i++) begin
      if (mag12(ch[i]) > {1'b0, cfg_i.valid_lim}) bad = 1'b1;
    end

    clamp_s = $signed({2'b00, cfg_i.clamp});
    for (int i = 0; i < 5; i++) begin
      chz[i] = bad ? 12'sd0 : ch[i];
      if (mag12(chz[i]) <= {5'd0, cfg_i.dead}) chz[i] = 12'sd0;
    end
    for (int i = 0; i < 4; i++) begin
      if (chz[i] > clamp_s) chz[i] = clamp_s;
      else if (chz[i] < -clamp_s) chz[i] = -clamp_s;
    end
    // wheel is not clamped, only saturated to its field
    if (chz[4] > 12'sd1023) chz[4] = 12'sd1023;
    else if (chz[4] < -12'sd1024) chz[4] = -12'sd1024;

    for (int i = 0; i < 5; i++) chan_d[i] = chan_q[i];
    for (int i = 0; i < 3; i++) mouse_d[i] = mouse_q[i];
    btn_l_d   = btn_l_q;
    btn_r_d   = btn_r_q;
    keys_d    = keys_q;
    sw_d      = sw_q;
    last_sw_d = last_sw_q;

    if (take_o) begin
      if (reject) begin
        sw_d = last_sw_q;
      end else begin
        for (int i = 0; i < 5; i++) chan_d[i] = chz[i][10:0];
        for (int i = 0; i < 3; i++) mouse_d[i] = {b[7+2*i], b[6+2*i]};
        btn_l_d   = b[12];
        btn_r_d   = b[13];
        keys_d    = {b[15], b[14]};
        sw_d      = bad ? 4'd0 : {s1, s2};
        last_sw_d = bad ? 4'd0 : {s1, s2};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 5; i++) chan_q[i] <= '0;
      for (int i = 0; i < 3; i++) mouse_q[i] <= '0;
      btn_l_q   <= '0;
      btn_r_q   <= '0;
      keys_q    <= '0;
      sw_q      <= '0;
      last_sw_q <= '0;
      vld_q     <= 1'b0;
    end else begin
      for (int i = 0; i < 5; i++) chan_q[i] <= chan_d[i];
      for (int i = 0; i < 3; i++) mouse_q[i] <= mouse_d[i];
      btn_l_q   <= btn_l_d;
      btn_r_q   <= btn_r_d;
      keys_q    <= keys_d;
      sw_q      <= sw_d;
      last_sw_q <= last_sw_d;
      if (take_o) vld_q <= 1'b1;
      else if (out_rdy_i) vld_q <= 1'b0;
    end
  end

  // held values only change on a take, which waits for the output to be free
  assign out_vld_o  = vld_q;
  assign out_data_o = {5'd0, sw_q, keys_q, btn_r_q, btn_l_q,
                       mouse_q[2], mouse_q[1], mouse_q[0],
                       chan_q[4], chan_q[3], chan_q[2], chan_q[1], chan_q[0]};

endmodule

// File: sv/rcfd_checker.sv
// rcfd_checker: port-level assertions for rc_frame_decoder_core
// depends on rcfd_pkg; attached by the bind below
module rcfd_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [rcfd_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
  import rcfd_pkg::*;

  logic [3:0] sw;
  assign sw = m_axis_tdata[138:135];

  // a waiting result holds steady
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // input only stalls behind a blocked result
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without output backpressure");

  // both switches are zero together or neither is
  a_sw_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((sw[3:2] == 2'd0) == (sw[1:0] == 2'd0)))
    else $error("one switch zero, the other not");

  // cleared switches only come with cleared channels
  a_sw_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && sw == 4'd0 |-> m_axis_tdata[54:0] == 55'd0)
    else $error("switches cleared but channels not");

endmodule

bind rc_frame_decoder_core rcfd_checker u_rcfd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// File: tb/sv/rc_frame_decoder_core_tb.sv
// rc_frame_decoder_core_tb: self-checking bench for the rc frame decoder, streaming bytes
// in and comparing every decoded result field by field against an in-bench decoder model
// depends on rcfd_pkg and rc_frame_decoder_core
module rc_frame_decoder_core_tb;
  import rcfd_pkg::*;

  localparam int LIMIT      = 400000;
  localparam int NUM_PHASES = 8;
  localparam int FRAMES_PER = 8;
  localparam int NUM_FIELDS = 13;

  typedef struct packed {
    logic       hold;
    logic       start;
    logic [7:0] data;
  } rx_byte_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [7:0]            s_axis_tdata  = '0;
  logic                  s_axis_tuser  = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i     = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;

  rc_frame_decoder_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  rx_byte_t              pending_bytes [$];
  rx_byte_t              next_byte;
  logic [OUT_DATA_W-1:0] expected_decodes [$];
  int                    src_idle   = 0;
  int                    sink_stall = 0;
  int                    errors     = 0;
  int                    cycles     = 0;
  logic                  in_took    = 1'b0;

  // field layout of m_axis_tdata, lowest bits first, padding last
  int    fld_w [NUM_FIELDS]    = '{11, 11, 11, 11, 11, 16, 16, 16, 8, 8, 16, 4, 5};
  string fld_name [NUM_FIELDS] = '{"stick_right_x", "stick_right_y", "stick_left_x",
                                   "stick_left_y", "wheel_channel", "mouse_dx", "mouse_dy",
                                   "mouse_dz", "button_left", "button_right", "key_bits",
                                   "switch_pair", "padding"};

  // decoder model: configuration and held state
  logic [10:0] cfg_center = CENTER_RST;
  logic [10:0] cfg_valid  = VALID_RST;
  logic [6:0]  cfg_dead   = DEAD_RST;
  logic [9:0]  cfg_clamp  = CLAMP_RST;
  logic [7:0]  frame_buf [17];
  int          frame_pos = 0;
  logic [10:0] held_ch [5];
  logic [15:0] held_mouse [3];
  logic [7:0]  held_btn [2];
  logic [15:0] held_keys;
  logic [1:0]  held_sw [2];
  logic [1:0]  last_sw [2];

  task automatic flag_error(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    errors++;
  endtask

  task automatic take_byte(input logic [7:0] b, input logic st);
    logic [7:0] f [18];
    int         raw [5];
    int         ch [5];
    int         mg;
    logic [1:0] s1, s2;
    logic       bad;
    if (st) begin
      frame_buf[0] = b;
      frame_pos = 1;
    end else if (frame_pos == 0) begin
      // idle, byte ignored
    end else if (frame_pos < 17) begin
      frame_buf[frame_pos] = b;
      frame_pos++;
    end else begin
      frame_pos = 0;
      for (int i = 0; i < 17; i++) f[i] = frame_buf[i];
      f[17] = b;
      s1 = f[5][7:6];
      s2 = f[5][5:4];
      if (s1 == 2'd0 || s2 == 2'd0) begin
        // rejected frame: switches fall back, everything else holds
        held_sw[0] = last_sw[0];
        held_sw[1] = last_sw[1];
      end else begin
        raw[0] = {f[1][2:0], f[0]};
        raw[1] = {f[2][5:0], f[1][7:3]};
        raw[2] = {f[4][0], f[3], f[2][7:6]};
        raw[3] = {f[5][3:0], f[4][7:1]};
        raw[4] = {f[17][2:0], f[16]};
        for (int i = 0; i < 5; i++) ch[i] = raw[i] - int'(cfg_center);
        for (int i = 0; i < 3; i++) held_mouse[i] = {f[7 + 2 * i], f[6 + 2 * i]};
        held_btn[0] = f[12];
        held_btn[1] = f[13];
        held_keys   = {f[15], f[14]};
        held_sw[0]  = s1;
        held_sw[1]  = s2;
        last_sw[0]  = s1;
        last_sw[1]  = s2;
        bad = 1'b0;
        for (int i = 0; i < 4; i++) begin
          mg = (ch[i] < 0) ? -ch[i] : ch[i];
          if (mg > int'(cfg_valid)) bad = 1'b1;
        end
        if (bad) begin
          for (int i = 0; i < 5; i++) ch[i] = 0;
          held_sw[0] = 2'd0;
          held_sw[1] = 2'd0;
          last_sw[0] = 2'd0;
          last_sw[1] = 2'd0;
        end
        for (int i = 0; i < 5; i++) begin
          mg = (ch[i] < 0) ? -ch[i] : ch[i];
          if (mg <= int'(cfg_dead)) ch[i] = 0;
        end
        for (int i = 0; i < 4; i++) begin
          if (ch[i] > int'(cfg_clamp)) ch[i] = int'(cfg_clamp);
          if (ch[i] < -int'(cfg_clamp)) ch[i] = -int'(cfg_clamp);
        end
        // wheel only saturates to its field
        if (ch[4] > 1023) ch[4] = 1023;
        if (ch[4] < -1024) ch[4] = -1024;
        for (int i = 0; i < 5; i++) held_ch[i] = ch[i][10:0];
      end
      expected_decodes.push_back({5'd0, held_sw[0], held_sw[1], held_keys, held_btn[1],
                                  held_btn[0], held_mouse[2], held_mouse[1], held_mouse[0],
                                  held_ch[4], held_ch[3], held_ch[2], held_ch[1],
                                  held_ch[0]});
    end
  endtask

  task automatic check_decode(input logic [OUT_DATA_W-1:0] got);
    logic [OUT_DATA_W-1:0] want, mask, g, w;
    int                    off;
    if (expected_decodes.size() == 0) begin
      flag_error($sformatf("result %h with nothing expected", got));
    end else begin
      want = expected_decodes.pop_front();
      off = 0;
      for (int k = 0; k < NUM_FIELDS; k++) begin
        mask = '0;
        mask[0] = 1'b1;
        mask = (mask << fld_w[k]) - 1'b1;
        g = (got >> off) & mask;
        w = (want >> off) & mask;
        if (g != w)
          flag_error($sformatf("%s got %0h want %0h", fld_name[k], g[15:0], w[15:0]));
        off += fld_w[k];
      end
    end
  endtask

  // byte driver and result ready, both change on the falling edge
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= sink_stall);
    if (rst_ni && (!s_axis_tvalid || in_took)) begin
      if (pending_bytes.size() != 0 && !(pending_bytes[0].hold && expected_decodes.size() != 0)
          && $urandom_range(99) >= src_idle) begin
        next_byte = pending_bytes.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= next_byte.data;
        s_axis_tuser  <= next_byte.start;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // both handshakes sampled at the rising edge
  always @(posedge clk_i) begin
    in_took <= rst_ni && s_axis_tvalid && s_axis_tready;
    if (rst_ni && s_axis_tvalid && s_axis_tready) take_byte(s_axis_tdata, s_axis_tuser);
    if (rst_ni && m_axis_tvalid && m_axis_tready) check_decode(m_axis_tdata);
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("rc_frame_decoder_core_tb: errors");
      $finish;
    end
  end

  task automatic write_reg(input cfg_idx_e idx, input logic [10:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_CENTER: cfg_center = val;
      CFG_VALID:  cfg_valid  = val;
      CFG_DEAD:   cfg_dead   = val[6:0];
      CFG_CLAMP:  cfg_clamp  = val[9:0];
      default:    ;
    endcase
  endtask

  task automatic set_config(input int c, input int v, input int d, input int k);
    write_reg(CFG_CENTER, c[10:0]);
    write_reg(CFG_VALID, v[10:0]);
    write_reg(CFG_DEAD, d[10:0]);
    write_reg(CFG_CLAMP, k[10:0]);
  endtask

  task automatic add_bytes(input int n, input logic first_start);
    rx_byte_t it;
    for (int i = 0; i < n; i++) begin
      it.hold  = 1'b0;
      it.start = (i == 0) ? first_start : 1'b0;
      it.data  = 8'($urandom);
      pending_bytes.push_back(it);
    end
  endtask

  // fill: 0 zeros, 1 ones, 2 random for the bytes not carrying channels or switches
  task automatic add_frame(input logic [10:0] r0, r1, r2, r3, r4,
                           input logic [1:0] sw1, sw2, input int fill, input logic hold);
    logic [7:0] f [18];
    logic [7:0] fb;
    rx_byte_t   it;
    for (int i = 0; i < 18; i++) begin
      fb = (fill == 0) ? 8'h00 : (fill == 1) ? 8'hFF : 8'($urandom);
      f[i] = fb;
    end
    f[0]  = r0[7:0];
    f[1]  = {r1[4:0], r0[10:8]};
    f[2]  = {r2[1:0], r1[10:5]};
    f[3]  = r2[9:2];
    f[4]  = {r3[6:0], r2[10]};
    f[5]  = {sw1, sw2, r3[10:7]};
    f[16] = r4[7:0];
    f[17] = {f[17][7:3], r4[10:8]};
    for (int i = 0; i < 18; i++) begin
      it.hold  = (i == 0) ? hold : 1'b0;
      it.start = (i == 0);
      it.data  = f[i];
      pending_bytes.push_back(it);
    end
  endtask

  function automatic logic [10:0] pick_raw(input logic corrupt);
    int off;
    if (corrupt) begin
      off = int'(cfg_valid) + 1 + int'($urandom_range(1023));
    end else begin
      case ($urandom_range(4))
        0:       off = int'($urandom_range(cfg_dead));
        1:       off = int'(cfg_dead) + 1;
        2:       off = int'(cfg_valid);
        3:       off = int'(cfg_clamp) + int'($urandom_range(1));
        default: off = int'($urandom_range(cfg_valid));
      endcase
      if (off > int'(cfg_valid)) off = int'(cfg_valid);
    end
    if ($urandom_range(1) != 0) off = -off;
    off += int'(cfg_center);
    if (off < 0) off = 0;
    if (off > 2047) off = 2047;
    return off[10:0];
  endfunction

  task automatic drain();
    while (pending_bytes.size() != 0 || s_axis_tvalid || expected_decodes.size() != 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  initial begin
    logic [10:0] rw [5];
    logic [1:0]  sw1, sw2;
    logic        bad;
    int          bc, kind;
    for (int i = 0; i < 5; i++) held_ch[i] = '0;
    for (int i = 0; i < 3; i++) held_mouse[i] = '0;
    for (int i = 0; i < 2; i++) begin
      held_btn[i] = '0;
      held_sw[i]  = '0;
      last_sw[i]  = '0;
    end
    held_keys = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0:       set_config(1024, 660, 6, 650);
        1:       set_config(0, 1024, 0, 1023);
        2:       set_config(2047, 0, 64, 0);
        3:       set_config(1024, 1024, 64, 1023);
        4:       set_config(512, 300, 20, 100);
        5:       set_config($urandom_range(2047), $urandom_range(1024), $urandom_range(64),
                            $urandom_range(1023));
        6:       set_config(1536, 700, 1, 1000);
        default: set_config(1024, 660, 6, 650);
      endcase
      case (ph % 4)
        0:       begin src_idle = 0;  sink_stall = 0;  end
        1:       begin src_idle = 68; sink_stall = 0;  end
        2:       begin src_idle = 0;  sink_stall = 68; end
        default: begin src_idle = 21; sink_stall = 21; end
      endcase

      if (ph == 0) begin
        add_bytes(2, 1'b0);  // stray items while idle
        // clamp edge, valid edge, dead zone edges, wheel at top and at bottom
        add_frame(11'd1674, 11'd364, 11'd1030, 11'd1017, 11'd2047, 2'd3, 2'd3, 1, 1'b0);
        add_frame(11'd1675, 11'd373, 11'd1018, 11'd1031, 11'd0, 2'd1, 2'd2, 0, 1'b0);
        // rejected frames, one switch and then the other reads zero
        add_frame(pick_raw(0), pick_raw(0), pick_raw(0), pick_raw(0), 11'd500,
                  2'd0, 2'd1, 2, 1'b0);
        add_frame(pick_raw(0), pick_raw(0), pick_raw(0), pick_raw(0), 11'd900,
                  2'd2, 2'd0, 2, 1'b0);
        // corrupt channel, then a rejected frame restores the cleared switches
        add_frame(11'd1685, 11'd1024, 11'd1024, 11'd1024, 11'd1024, 2'd2, 2'd1, 2, 1'b0);
        add_frame(pick_raw(0), pick_raw(0), pick_raw(0), pick_raw(0), 11'd1,
                  2'd0, 2'd3, 2, 1'b0);
        // abandoned frames, the second cut on its final byte
        add_bytes(10, 1'b1);
        add_frame(pick_raw(0), pick_raw(0), pick_raw(0), pick_raw(0), 11'd1024,
                  2'd1, 2'd1, 2, 1'b1);
        add_bytes(17, 1'b1);
        add_frame(pick_raw(0), 11'd0, pick_raw(0), pick_raw(0), 11'd2047, 2'd3, 2'd2, 2, 1'b0);
      end

      for (int n = 0; n < FRAMES_PER; n++) begin
        kind = $urandom_range(99);
        if (kind < 5) add_bytes($urandom_range(3, 1), 1'b0);
        else if (kind < 11) add_bytes($urandom_range(17, 1), 1'b1);
        kind = $urandom_range(99);
        sw1 = 2'($urandom_range(3, 1));
        sw2 = 2'($urandom_range(3, 1));
        if (kind < 10) begin
          case ($urandom_range(2))
            0:       sw1 = 2'd0;
            1:       sw2 = 2'd0;
            default: begin sw1 = 2'd0; sw2 = 2'd0; end
          endcase
        end
        bad = (kind >= 88);
        bc  = $urandom_range(3);
        for (int c = 0; c < 4; c++) rw[c] = pick_raw(bad && c == bc);
        rw[4] = ($urandom_range(1) != 0) ? 11'($urandom_range(2047)) : pick_raw(0);
        add_frame(rw[0], rw[1], rw[2], rw[3], rw[4], sw1, sw2, 2, $urandom_range(15) == 0);
      end
      drain();
    end

    if (errors == 0) begin
      $display("rc_frame_decoder_core_tb: clean");
    end else begin
      $display("rc_frame_decoder_core_tb: errors");
    end
    $finish;
  end

endmodule
